// ===== hw/rtl/wav_hdr_pkg.sv =====
`default_nettype none
package wav_hdr_pkg;

  // four-character codes, first character in the lowest byte
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam int unsigned DVD_W  = 33;
  localparam int unsigned DVSR_W = 16;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNC     = 4'd1;
  localparam logic [3:0] ST_BAD_MAGIC = 4'd2;
  localparam logic [3:0] ST_NO_FMT    = 4'd3;
  localparam logic [3:0] ST_FMT_SHORT = 4'd4;
  localparam logic [3:0] ST_NOT_PCM   = 4'd5;
  localparam logic [3:0] ST_ZERO_CH   = 4'd6;
  localparam logic [3:0] ST_BAD_BITS  = 4'd7;
  localparam logic [3:0] ST_BAD_CONT  = 4'd8;
  localparam logic [3:0] ST_NO_DATA   = 4'd9;

  localparam logic [2:0] FMT_U8    = 3'd0;
  localparam logic [2:0] FMT_S16   = 3'd1;
  localparam logic [2:0] FMT_S24_3 = 3'd2;
  localparam logic [2:0] FMT_S24_4 = 3'd3;
  localparam logic [2:0] FMT_S32   = 3'd4;

  localparam logic [15:0] TAG_PCM = 16'd1;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // declared high field first so that status sits in the lowest bits
  typedef struct packed {
    logic [31:0] data_start;
    logic [32:0] frame_total;
    logic [32:0] data_bytes;
    logic [15:0] sample_bits;
    logic [2:0]  sample_format;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [3:0]  status;
  } result_t;

  typedef enum logic [6:0] {
    PH_RIFF      = 7'b000_0001,
    PH_FMT_HDR   = 7'b000_0010,
    PH_FMT_SKIP  = 7'b000_0100,
    PH_FMT_BODY  = 7'b000_1000,
    PH_DATA_HDR  = 7'b001_0000,
    PH_DATA_SKIP = 7'b010_0000,
    PH_DONE      = 7'b100_0000
  } phase_e;

  typedef enum logic [2:0] {
    SQ_RUN   = 3'b001,
    SQ_CONT  = 3'b010,
    SQ_FRAME = 3'b100
  } seq_e;

endpackage
`default_nettype wire

// ===== hw/rtl/wav_hdr_div.sv =====
`default_nettype none
module wav_hdr_div
  import wav_hdr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;   // dividend shifts out, quotient shifts in
  logic [DVSR_W-1:0] rem_q, rem_d;
  logic [DVSR_W-1:0] dvsr_q, dvsr_d;
  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      dvd_d  = req_i.dividend;
      dvsr_d = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvsr_q}) begin
        rem_d = diff[DVSR_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVSR_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule
`default_nettype wire

// ===== hw/rtl/wav_header_parser.sv =====
// result: a transaction is registered in the cycle after the byte that decides it;
//   the container check of a 24-bit fmt chunk and the frame count at the data header
//   each go first through the one-bit-per-cycle shared divider
// throughput: one byte per cycle, except while the divider runs or a result waits
// reset: asynchronous, active low; clears the parser to the start of a file
`default_nettype none
module wav_header_parser
  import wav_hdr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // file_byte[7:0]
  input  wire logic         s_axis_tlast,   // last_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[3:0], channel_count[19:4], sample_rate[51:20], sample_format[54:52],
  // sample_bits[70:55], data_bytes[103:71], frame_total[136:104],
  // data_start[168:137], zero fill[175:169]
  output logic [175:0]      m_axis_tdata
);

  // parser state
  phase_e      phase_q, phase_d;
  seq_e        seq_q, seq_d;
  logic [31:0] pos_q, pos_d;          // bytes taken in this file up to the result
  logic [3:0]  fs_q, fs_d;            // byte index within header or fmt body
  logic [31:0] kind_q, kind_d;        // chunk id or magic word
  logic [32:0] skip_q, skip_d;        // chunk length, then bytes left to skip
  logic [32:0] fmt_len_q, fmt_len_d;
  logic [15:0] tag_q, tag_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] align_q, align_d;
  logic [15:0] bits_q, bits_d;
  logic [2:0]  code_q, code_d;
  logic        pend_last_q, pend_last_d; // file ended on the byte that started a divide

  // output register
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;

  // shared divider
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        accept;
  logic [7:0]  b;
  logic        emit;
  logic [3:0]  emit_status;
  logic [32:0] emit_frames;
  logic        rearm;
  logic        start_cont;
  logic        start_frame;
  logic [32:0] hdr_len;
  logic [32:0] hdr_pad;
  logic [31:0] word4;
  logic [15:0] bits_full;

  assign s_axis_tready = (seq_q == SQ_RUN) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  // values completed by the byte now arriving
  assign hdr_len   = {1'b0, b, skip_q[23:0]};
  assign hdr_pad   = hdr_len + {32'd0, hdr_len[0]};
  assign word4     = {b, kind_q[23:0]};
  assign bits_full = {b, bits_q[7:0]};

  always_comb begin
    phase_d     = phase_q;
    seq_d       = seq_q;
    pos_d       = pos_q;
    fs_d        = fs_q;
    kind_d      = kind_q;
    skip_d      = skip_q;
    fmt_len_d   = fmt_len_q;
    tag_d       = tag_q;
    ch_d        = ch_q;
    rate_d      = rate_q;
    align_d     = align_q;
    bits_d      = bits_q;
    code_d      = code_q;
    pend_last_d = pend_last_q;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_frames = '0;
    rearm       = 1'b0;
    start_cont  = 1'b0;
    start_frame = 1'b0;

    if (accept) begin
      if (phase_q != PH_DONE) begin
        pos_d = pos_q + 32'd1;
      end
      unique case (phase_q) inside
        PH_RIFF: begin
          fs_d = fs_q + 4'd1;
          // bytes 4 to 7 carry the riff size, which is not used
          if (fs_q[3:2] != 2'b01) begin
            if (fs_q[1:0] == 2'd0) begin
              kind_d = {24'd0, b};
            end else begin
              kind_d[{fs_q[1:0], 3'b000} +: 8] = b;
            end
          end
          if (fs_q == 4'd3 && word4 != ID_RIFF) begin
            emit        = 1'b1;
            emit_status = ST_BAD_MAGIC;
          end else if (fs_q == 4'd11) begin
            fs_d = 4'd0;
            if (word4 != ID_WAVE) begin
              emit        = 1'b1;
              emit_status = ST_BAD_MAGIC;
            end else begin
              phase_d = PH_FMT_HDR;
            end
          end
        end
        PH_FMT_HDR, PH_DATA_HDR: begin
          fs_d = fs_q + 4'd1;
          if (fs_q[2:0] == 3'd0) begin
            kind_d = {24'd0, b};
            skip_d = '0;
          end else if (!fs_q[2]) begin
            kind_d[{fs_q[1:0], 3'b000} +: 8] = b;
          end else begin
            skip_d[{fs_q[1:0], 3'b000} +: 8] = b;
          end
          if (fs_q[2:0] == 3'd7) begin
            // header complete: length padded to even in 33 bits
            fs_d   = 4'd0;
            skip_d = hdr_pad;
            if (phase_q == PH_FMT_HDR) begin
              if (kind_q == ID_FMT) begin
                if (hdr_pad < 33'd16) begin
                  emit        = 1'b1;
                  emit_status = ST_FMT_SHORT;
                end else begin
                  fmt_len_d = hdr_pad;
                  phase_d   = PH_FMT_BODY;
                end
              end else if (hdr_pad != '0) begin
                phase_d = PH_FMT_SKIP;
              end
            end else begin
              if (kind_q == ID_DATA) begin
                if (align_q == '0) begin
                  emit        = 1'b1;
                  emit_status = ST_OK;
                end else begin
                  start_frame = 1'b1;
                end
              end else if (hdr_pad != '0) begin
                phase_d = PH_DATA_SKIP;
              end
            end
          end
        end
        PH_FMT_SKIP, PH_DATA_SKIP: begin
          skip_d = skip_q - 33'd1;
          if (skip_q == 33'd1) begin
            phase_d = (phase_q == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
          end
        end
        PH_FMT_BODY: begin
          fs_d = fs_q + 4'd1;
          case (fs_q) inside
            4'd0, 4'd1:         tag_d[{fs_q[0], 3'b000} +: 8] = b;
            4'd2, 4'd3:         ch_d[{fs_q[0], 3'b000} +: 8] = b;
            4'd4, 4'd5,
            4'd6, 4'd7:         rate_d[{fs_q[1:0], 3'b000} +: 8] = b;
            4'd12, 4'd13:       align_d[{fs_q[0], 3'b000} +: 8] = b;
            4'd14, 4'd15:       bits_d[{fs_q[0], 3'b000} +: 8] = b;
            default: begin
              // byte rate is not used
            end
          endcase
          if (fs_q == 4'd15) begin
            skip_d  = fmt_len_q - 33'd16;
            phase_d = (fmt_len_q != 33'd16) ? PH_DATA_SKIP : PH_DATA_HDR;
            if (tag_q != TAG_PCM) begin
              emit        = 1'b1;
              emit_status = ST_NOT_PCM;
            end else if (ch_q == '0) begin
              emit        = 1'b1;
              emit_status = ST_ZERO_CH;
            end else begin
              case (bits_full)
                16'd8:   code_d = FMT_U8;
                16'd16:  code_d = FMT_S16;
                16'd32:  code_d = FMT_S32;
                16'd24:  start_cont = 1'b1;
                default: begin
                  emit        = 1'b1;
                  emit_status = ST_BAD_BITS;
                end
              endcase
            end
          end
        end
        PH_DONE: begin
          // rest of the file is dropped
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase

      if (start_cont || start_frame) begin
        pend_last_d = s_axis_tlast;
        seq_d       = start_cont ? SQ_CONT : SQ_FRAME;
      end else begin
        if (!emit && s_axis_tlast && phase_q != PH_DONE) begin
          emit = 1'b1;
          unique case (phase_d)
            PH_FMT_HDR:   emit_status = (fs_d != '0) ? ST_TRUNC : ST_NO_FMT;
            PH_FMT_SKIP:  emit_status = ST_NO_FMT;
            PH_DATA_HDR:  emit_status = (fs_d != '0) ? ST_TRUNC : ST_NO_DATA;
            PH_DATA_SKIP: emit_status = ST_NO_DATA;
            default:      emit_status = ST_TRUNC;
          endcase
        end
        rearm = s_axis_tlast;
      end
    end

    // divider completion
    if (seq_q == SQ_CONT && div_rsp.done) begin
      seq_d = SQ_RUN;
      rearm = pend_last_q;
      if (div_rsp.quotient == 33'd3) begin
        code_d = FMT_S24_3;
      end else if (div_rsp.quotient == 33'd4) begin
        code_d = FMT_S24_4;
      end else begin
        emit        = 1'b1;
        emit_status = ST_BAD_CONT;
      end
      // file ended with the fmt chunk: the data search is left at a chunk boundary
      if (!emit && pend_last_q) begin
        emit        = 1'b1;
        emit_status = ST_NO_DATA;
      end
    end
    if (seq_q == SQ_FRAME && div_rsp.done) begin
      seq_d       = SQ_RUN;
      rearm       = pend_last_q;
      emit        = 1'b1;
      emit_status = ST_OK;
      emit_frames = div_rsp.quotient;
    end

    // output register
    out_valid_d = out_valid_q && !m_axis_tready;
    res_d       = res_q;
    if (emit) begin
      phase_d     = PH_DONE;
      out_valid_d = 1'b1;
      res_d       = '0;
      res_d.status = emit_status;
      if (emit_status == ST_OK) begin
        res_d.channel_count = ch_d;
        res_d.sample_rate   = rate_d;
        res_d.sample_format = code_d;
        res_d.sample_bits   = bits_d;
        res_d.data_bytes    = skip_d;
        res_d.frame_total   = emit_frames;
        res_d.data_start    = pos_d;
      end
    end

    // last byte of the file: back to the start state
    if (rearm) begin
      phase_d     = PH_RIFF;
      pos_d       = '0;
      fs_d        = '0;
      kind_d      = '0;
      skip_d      = '0;
      fmt_len_d   = '0;
      tag_d       = '0;
      ch_d        = '0;
      rate_d      = '0;
      align_d     = '0;
      bits_d      = '0;
      code_d      = FMT_U8;
      pend_last_d = 1'b0;
    end
  end

  // divider operands: container size at fmt end, frame count at data header
  assign div_req.start    = start_cont || start_frame;
  assign div_req.dividend = start_cont ? {17'd0, align_q} : hdr_pad;
  assign div_req.divisor  = start_cont ? ch_q : align_q;

  wav_hdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RIFF;
      seq_q       <= SQ_RUN;
      pos_q       <= '0;
      fs_q        <= '0;
      kind_q      <= '0;
      skip_q      <= '0;
      fmt_len_q   <= '0;
      tag_q       <= '0;
      ch_q        <= '0;
      rate_q      <= '0;
      align_q     <= '0;
      bits_q      <= '0;
      code_q      <= FMT_U8;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      pos_q       <= pos_d;
      fs_q        <= fs_d;
      kind_q      <= kind_d;
      skip_q      <= skip_d;
      fmt_len_q   <= fmt_len_d;
      tag_q       <= tag_d;
      ch_q        <= ch_d;
      rate_q      <= rate_d;
      align_q     <= align_d;
      bits_q      <= bits_d;
      code_q      <= code_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, held while the transaction waits
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q};

endmodule
`default_nettype wire

// ===== verif/wav_header_checker.sv =====
`timescale 1ns / 1ps
module wav_header_checker
  import wav_hdr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  input  wire logic [7:0]   s_tdata_i,
  input  wire logic         s_tlast_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  input  wire logic [175:0] m_tdata_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       parsed_o,
  output int unsigned       results_o,
  output logic [15:0]       status_seen_o
);

  // parser copy
  phase_e      phase;
  logic [31:0] pos;
  logic [31:0] idx;
  logic [31:0] kind;
  logic [32:0] remain;
  logic [32:0] fmt_len;
  logic [15:0] tag;
  logic [15:0] chans;
  logic [31:0] rate;
  logic [15:0] balign;
  logic [15:0] bits;
  bit          answered;

  result_t predicted_reports[$];

  task automatic clear_parser();
    phase    = PH_RIFF;
    pos      = '0;
    idx      = '0;
    kind     = '0;
    remain   = '0;
    fmt_len  = '0;
    tag      = '0;
    chans    = '0;
    rate     = '0;
    balign   = '0;
    bits     = '0;
    answered = 1'b0;
  endtask

  // type in bytes 0-3, length in bytes 4-7; length padded to even when complete
  function automatic bit take_header_byte(input logic [7:0] b);
    logic [2:0] i;
    i = idx[2:0];
    if (i == 3'd0) begin
      kind   = '0;
      remain = '0;
    end
    if (i < 3'd4) kind[8*i +: 8] = b;
    else remain[8*(i-4) +: 8] = b;
    idx = 32'(i) + 32'd1;
    if (idx < 32'd8) return 1'b0;
    idx    = '0;
    remain = remain + {32'b0, remain[0]};
    return 1'b1;
  endfunction

  function automatic logic [3:0] fmt_verdict(output logic [2:0] code);
    logic [15:0] cont;
    code = FMT_U8;
    if (tag != TAG_PCM) return ST_NOT_PCM;
    if (chans == 16'd0) return ST_ZERO_CH;
    case (bits)
      16'd8:  code = FMT_U8;
      16'd16: code = FMT_S16;
      16'd24: begin
        cont = balign / chans;
        if (cont == 16'd3) code = FMT_S24_3;
        else if (cont == 16'd4) code = FMT_S24_4;
        else return ST_BAD_CONT;
      end
      16'd32: code = FMT_S32;
      default: return ST_BAD_BITS;
    endcase
    return ST_OK;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic is_last);
    bit          emit;
    logic [3:0]  st;
    logic [2:0]  code;
    logic [31:0] i;
    result_t     r;
    emit = 1'b0;
    st   = ST_OK;
    if (!answered) begin
      parsed_o++;
      pos = pos + 32'd1;
      case (phase)
        PH_RIFF: begin
          i = idx;
          if (i == 32'd0 || i == 32'd8) kind = '0;
          if (i < 32'd4) kind[8*i +: 8] = b;
          else if (i >= 32'd8 && i < 32'd12) kind[8*(i-8) +: 8] = b;
          idx = i + 32'd1;
          if (i == 32'd3 && kind != ID_RIFF) begin
            emit = 1'b1;
            st   = ST_BAD_MAGIC;
          end else if (i >= 32'd11) begin
            idx = '0;
            if (kind != ID_WAVE) begin
              emit = 1'b1;
              st   = ST_BAD_MAGIC;
            end else begin
              phase = PH_FMT_HDR;
            end
          end
        end
        PH_FMT_HDR: begin
          if (take_header_byte(b)) begin
            if (kind == ID_FMT) begin
              if (remain < 33'd16) begin
                emit = 1'b1;
                st   = ST_FMT_SHORT;
              end else begin
                fmt_len = remain;
                phase   = PH_FMT_BODY;
              end
            end else if (remain != '0) begin
              phase = PH_FMT_SKIP;
            end
          end
        end
        PH_FMT_SKIP: begin
          remain = remain - 33'd1;
          if (remain == '0) phase = PH_FMT_HDR;
        end
        PH_FMT_BODY: begin
          i = idx & 32'd15;
          if (i == 32'd0) begin
            tag    = '0;
            chans  = '0;
            rate   = '0;
            balign = '0;
            bits   = '0;
          end
          // byte rate (bytes 8-11) is not kept
          if (i < 32'd2) tag[8*i +: 8] = b;
          else if (i < 32'd4) chans[8*(i-2) +: 8] = b;
          else if (i < 32'd8) rate[8*(i-4) +: 8] = b;
          else if (i >= 32'd12 && i < 32'd14) balign[8*(i-12) +: 8] = b;
          else if (i >= 32'd14) bits[8*(i-14) +: 8] = b;
          idx = i + 32'd1;
          if (i == 32'd15) begin
            idx = '0;
            st  = fmt_verdict(code);
            if (st != ST_OK) begin
              emit = 1'b1;
            end else begin
              remain = fmt_len - 33'd16;
              phase  = (remain != '0) ? PH_DATA_SKIP : PH_DATA_HDR;
            end
          end
        end
        PH_DATA_HDR: begin
          if (take_header_byte(b)) begin
            if (kind == ID_DATA) begin
              emit = 1'b1;
              st   = ST_OK;
            end else if (remain != '0) begin
              phase = PH_DATA_SKIP;
            end
          end
        end
        PH_DATA_SKIP: begin
          remain = remain - 33'd1;
          if (remain == '0) phase = PH_DATA_HDR;
        end
        default: ;
      endcase

      if (!emit && is_last) begin
        emit = 1'b1;
        case (phase)
          PH_FMT_HDR:   st = (idx != '0) ? ST_TRUNC : ST_NO_FMT;
          PH_FMT_SKIP:  st = ST_NO_FMT;
          PH_DATA_HDR:  st = (idx != '0) ? ST_TRUNC : ST_NO_DATA;
          PH_DATA_SKIP: st = ST_NO_DATA;
          default:      st = ST_TRUNC;
        endcase
      end
    end

    if (emit) begin
      r        = '0;
      r.status = st;
      if (st == ST_OK) begin
        void'(fmt_verdict(code));
        r.channel_count = chans;
        r.sample_rate   = rate;
        r.sample_format = code;
        r.sample_bits   = bits;
        r.data_bytes    = remain;
        r.frame_total   = (balign != '0) ? remain / balign : '0;
        r.data_start    = pos;
      end
      predicted_reports.push_back(r);
      answered = 1'b1;
      phase    = PH_DONE;
    end
    if (is_last) clear_parser();
  endtask

  task automatic field_check(input string name, input logic [32:0] want,
                             input logic [32:0] got);
    if (got !== want) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic check_report(input logic [175:0] word);
    result_t got;
    result_t want;
    got = word[$bits(result_t)-1:0];
    results_o++;
    if (predicted_reports.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: unexpected result, status %0d", $time, got.status);
      return;
    end
    want = predicted_reports.pop_front();
    status_seen_o[want.status] = 1'b1;
    field_check("status", want.status, got.status);
    field_check("channel_count", want.channel_count, got.channel_count);
    field_check("sample_rate", want.sample_rate, got.sample_rate);
    field_check("sample_format", want.sample_format, got.sample_format);
    field_check("sample_bits", want.sample_bits, got.sample_bits);
    field_check("data_bytes", want.data_bytes, got.data_bytes);
    field_check("frame_total", want.frame_total, got.frame_total);
    field_check("data_start", want.data_start, got.data_start);
    field_check("zero fill", '0, word[175:$bits(result_t)]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      predicted_reports.delete();
      fail_count_o  = 0;
      parsed_o      = 0;
      results_o     = 0;
      status_seen_o = '0;
    end else begin
      // a result always trails the byte that decides it, so retire first
      if (m_tvalid_i && m_tready_i) check_report(m_tdata_i);
      if (s_tvalid_i && s_tready_i) parse_byte(s_tdata_i, s_tlast_i);
    end
    pending_o = predicted_reports.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import wav_hdr_pkg::*;

  // the long output hold-off plus two divider runs must fit well inside this
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned HOLD_OFF_FILE   = 8;
  // two divider passes plus the result register
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned TARGET_BYTES    = 1950;
  localparam int unsigned CALM_BYTES      = 1600;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [175:0] m_axis_tdata;

  int unsigned  fail_count;
  int unsigned  pending;
  int unsigned  parsed;
  int unsigned  results;
  logic [15:0]  status_seen;

  // file image being built, and where its fmt and data headers begin
  logic [7:0]   wav_bytes[$];
  int unsigned  fmt_at;
  int unsigned  data_at;

  int unsigned  files_sent;
  int unsigned  bytes_sent;
  bit           calm;
  bit           held_off;
  int unsigned  stuck_cycles;

  wav_header_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wav_header_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tlast_i     (s_axis_tlast),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .parsed_o      (parsed),
    .results_o     (results),
    .status_seen_o (status_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // file image construction, all multi-byte fields little endian
  // ---------------------------------------------------------------------------

  task automatic put8(input logic [7:0] v);
    wav_bytes.push_back(v);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  // a chunk of no interest to the parser, odd lengths get a pad byte
  task automatic put_junk();
    int unsigned len;
    len = $urandom_range(0, 11);
    put32($urandom);
    put32(len);
    repeat (len + len % 2) put8(8'($urandom));
  endtask

  task automatic cut_at(input int unsigned n);
    while (wav_bytes.size() > n) void'(wav_bytes.pop_back());
  endtask

  // riff header, optional chunks, fmt chunk, optional chunks, data header and
  // a few sample bytes that the parser ignores
  task automatic make_wav(input logic [15:0] tag, input logic [15:0] chans,
                          input logic [31:0] rate, input logic [15:0] balign,
                          input logic [15:0] bits, input logic [31:0] fmt_len,
                          input logic [31:0] data_len, input int unsigned pre_junk,
                          input int unsigned post_junk);
    logic [32:0] padded;
    wav_bytes.delete();
    put32(ID_RIFF);
    put32($urandom);
    put32(ID_WAVE);
    repeat (pre_junk) put_junk();
    fmt_at = wav_bytes.size();
    put32(ID_FMT);
    put32(fmt_len);
    put16(tag);
    put16(chans);
    put32(rate);
    put32($urandom);
    put16(balign);
    put16(bits);
    padded = fmt_len + {32'b0, fmt_len[0]};
    if (padded > 33'd64) begin
      // huge fmt chunk: the file stops somewhere in its tail
      repeat ($urandom_range(1, 6)) put8(8'($urandom));
      data_at = wav_bytes.size();
      return;
    end
    if (padded > 33'd16) repeat (int'(padded) - 16) put8(8'($urandom));
    repeat (post_junk) put_junk();
    data_at = wav_bytes.size();
    put32(ID_DATA);
    put32(data_len);
    repeat ($urandom_range(0, 4)) put8(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // byte stream driver
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic send_file();
    for (int k = 0; k < wav_bytes.size(); k++)
      send_byte(wav_bytes[k], k == wav_bytes.size() - 1);
    files_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // directed files: every format code, every error and the corner lengths
  // ---------------------------------------------------------------------------

  task automatic directed_files();
    // 8-bit mono, largest data length pads to 2^32, zero block align gives no frames
    make_wav(TAG_PCM, 16'd1, 32'd8000, 16'd0, 16'd8, 32'd16, 32'hFFFF_FFFF, 0, 0);
    send_file();
    // fmt length 15 pads to 16 and passes; 24-bit in 3 bytes; junk chunks and odd data
    make_wav(TAG_PCM, 16'd2, 32'd44100, 16'd6, 16'd24, 32'd15, 32'd7, 1, 1);
    send_file();
    // all-ones channel count, rate and block align
    make_wav(TAG_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd16, 32'd18,
             32'hFFFF_FFFE, 0, 0);
    send_file();
    make_wav(TAG_PCM, 16'd1, 32'd48000, 16'd4, 16'd24, 32'd16, 32'd12, 0, 0);
    send_file();
    // 32-bit with an empty data chunk behind two foreign chunks
    make_wav(TAG_PCM, 16'd2, 32'd96000, 16'd8, 16'd32, 32'd16, 32'd0, 0, 2);
    send_file();
    // 24-bit container of 5 bytes
    make_wav(TAG_PCM, 16'd1, 32'd8000, 16'd5, 16'd24, 32'd16, 32'd10, 0, 0);
    send_file();
    // unsupported bit depth, non-pcm tag, no channels, fmt chunk too short
    make_wav(TAG_PCM, 16'd1, 32'd8000, 16'd2, 16'd12, 32'd16, 32'd10, 0, 0);
    send_file();
    make_wav(16'hFFFE, 16'd1, 32'd8000, 16'd2, 16'd16, 32'd16, 32'd10, 0, 0);
    send_file();
    make_wav(TAG_PCM, 16'd0, 32'd8000, 16'd2, 16'd16, 32'd16, 32'd10, 0, 0);
    send_file();
    make_wav(TAG_PCM, 16'd1, 32'd8000, 16'd2, 16'd16, 32'd14, 32'd10, 0, 0);
    send_file();
    // wrong first magic word, then wrong form type
    make_wav(TAG_PCM, 16'd1, 32'd8000, 16'd1, 16'd8, 32'd16, 32'd4, 0, 0);
    wav_bytes[3] = wav_bytes[3] ^ 8'h80;
    send_file();
    make_wav(TAG_PCM, 16'd1, 32'd8000, 16'd1, 16'd8, 32'd16, 32'd4, 0, 0);
    wav_bytes[11] = wav_bytes[11] ^ 8'h01;
    send_file();
    // end of file inside the fmt tail
    make_wav(TAG_PCM, 16'd1, 32'd8000, 16'd1, 16'd8, 32'd40, 32'd4, 0, 0);
    cut_at(40);
    send_file();
    // ever shorter copies: data header, fmt end, fmt body, fmt header,
    // chunk boundary, riff header, a single byte
    make_wav(TAG_PCM, 16'd1, 32'd8000, 16'd1, 16'd8, 32'd16, 32'd4, 0, 0);
    cut_at(40);
    send_file();
    cut_at(36);
    send_file();
    cut_at(25);
    send_file();
    cut_at(17);
    send_file();
    cut_at(12);
    send_file();
    cut_at(2);
    send_file();
    cut_at(1);
    send_file();
  endtask

  // ---------------------------------------------------------------------------
  // random files: mostly well formed with random fields, plus broken ones
  // ---------------------------------------------------------------------------

  task automatic random_file();
    int unsigned pick;
    int unsigned cont;
    int unsigned pos;
    logic [15:0] tag;
    logic [15:0] chans;
    logic [15:0] balign;
    logic [15:0] bits;
    logic [31:0] fmt_len;
    logic [31:0] data_len;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // plain noise
      wav_bytes.delete();
      repeat ($urandom_range(1, 30)) put8(8'($urandom));
      return;
    end
    tag = ($urandom_range(0, 9) == 0) ? 16'($urandom) : TAG_PCM;
    case ($urandom_range(0, 19))
      0:       chans = 16'd0;
      1, 2:    chans = 16'($urandom);
      default: chans = 16'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 9))
      0:       bits = 16'($urandom);
      1:       bits = 16'($urandom_range(0, 40));
      2, 3:    bits = 16'd8;
      4, 5:    bits = 16'd16;
      6, 7:    bits = 16'd24;
      default: bits = 16'd32;
    endcase
    cont = (bits == 16'd24) ? $urandom_range(3, 4) : 32'(bits) / 8;
    case ($urandom_range(0, 9))
      0:       balign = 16'($urandom);
      1:       balign = 16'd0;
      2:       balign = 16'(32'(chans) * $urandom_range(0, 6));
      default: balign = 16'(32'(chans) * cont);
    endcase
    case ($urandom_range(0, 11))
      0:       fmt_len = $urandom_range(0, 15);
      1:       fmt_len = 32'hFFFF_FFFF;
      2:       fmt_len = $urandom;
      3, 4:    fmt_len = $urandom_range(17, 40);
      default: fmt_len = 32'd16;
    endcase
    case ($urandom_range(0, 9))
      0:       data_len = 32'd0;
      1:       data_len = 32'hFFFF_FFFF;
      2:       data_len = 32'hFFFF_FFFE;
      3, 4:    data_len = $urandom;
      default: data_len = $urandom_range(0, 5000);
    endcase
    make_wav(tag, chans, $urandom, balign, bits, fmt_len, data_len,
             $urandom_range(0, 2), $urandom_range(0, 1));
    if (pick < 18) begin
      // single bit flip in the riff header, often in a magic word
      pos = $urandom_range(0, 11);
      wav_bytes[pos] = wav_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
    end else if (pick < 30) begin
      cut_at($urandom_range(1, wav_bytes.size()));
    end else if (pick < 34) begin
      cut_at(fmt_at);
    end else if (pick < 38) begin
      cut_at(data_at);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus and verdict
  // ---------------------------------------------------------------------------

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    files_sent    = 0;
    bytes_sent    = 0;
    calm          = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_files();
    while (bytes_sent < TARGET_BYTES) begin
      // no idling on either side in the closing stretch
      if (bytes_sent >= CALM_BYTES) calm = 1'b1;
      random_file();
      send_file();
    end
    s_axis_tvalid <= 1'b0;

    // every predicted result has to come out, then a quiet spell for strays
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d files, %0d input bytes, %0d parsed header bytes",
             files_sent, bytes_sent, parsed);
    $display("%0d result transactions, %0d of 10 status codes, one %0d-cycle hold-off",
             results, $countones(status_seen[9:0]), HOLD_OFF_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random ready bursts, one long hold-off that backs the parser up
  initial begin
    m_axis_tready = 1'b0;
    held_off      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && files_sent >= HOLD_OFF_FILE) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end else if (calm || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        if (!calm) repeat ($urandom_range(0, 29)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end
    end
  end

  // watchdog: too long without any transaction on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stuck_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/wav_hdr_pkg.sv
hw/rtl/wav_hdr_div.sv
hw/rtl/wav_header_parser.sv
verif/wav_header_checker.sv
verif/testbench.sv
